// ----- rtl/point_in_polygon_test_defines.svh -----
// assertion macros for the point-in-polygon test block
// every macro expects signals named clock and reset in the using module
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// condition in this cycle implies consequence in the same cycle
`define PIP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// condition in this cycle implies consequence in the next cycle
`define PIP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/pip_pkg.sv -----
// shared constants, codes and the sequencer-to-datapath control struct
// no dependencies
`default_nettype none

package pip_pkg;

   localparam int DEF_MAX_CORNERS = 16;
   localparam int DEF_COORD_BITS  = 16;
   localparam int MIN_CORNERS     = 3;
   localparam int COUNT_BITS      = 5;
   localparam int SLOT_BITS       = 4;

   localparam logic MODE_TEST  = 1'b0;
   localparam logic MODE_WRITE = 1'b1;

   typedef struct packed {
      logic clear;       // capture test point, clear inside flag
      logic load_old;    // ram data is the closing vertex
      logic load_edge;   // ram data is the next vertex of the walk
      logic mul_first;   // left product
      logic mul_second;  // right product
      logic compare;     // compare products and toggle
   } pip_ctl_type;

endpackage

`default_nettype wire

// ----- rtl/point_in_polygon_test.sv -----
// point-in-polygon test by crossing number; uses pip_pkg, pip_ram, pip_edge_dp
// vertex write, or test with fewer than 3 corners: result strobe in the cycle after
// start, block stays free, one such transaction per cycle
// test with n corners: busy until the result; prime, closing vertex, per edge a
// load on the one ram read port, two shared-multiplier products, compare; done
// synchronous reset clears corner_count and control; vertex ram is not cleared
`default_nettype none

`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int MAX_CORNERS = DEF_MAX_CORNERS,
   parameter int COORD_BITS  = DEF_COORD_BITS
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output      logic                  busy,
   input  wire logic                  req_mode,
   input  wire logic [SLOT_BITS-1:0]  req_vertex_slot,
   input  wire logic [COORD_BITS-1:0] req_coord_x,
   input  wire logic [COORD_BITS-1:0] req_coord_y,
   output      logic                  rsp_valid,
   output      logic                  rsp_inside_res,
   output      logic                  rsp_keep,
   input  wire logic                  csr_valid,
   output      logic                  csr_ready,
   input  wire logic [COUNT_BITS-1:0] csr_corner_count
);

   localparam int IDX_W = $clog2(MAX_CORNERS);
   localparam int CNT_W = $clog2(MAX_CORNERS + 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_PRIME = 3'd1;
   localparam logic [2:0] ST_OLD   = 3'd2;
   localparam logic [2:0] ST_EDGE  = 3'd3;
   localparam logic [2:0] ST_MUL1  = 3'd4;
   localparam logic [2:0] ST_MUL2  = 3'd5;
   localparam logic [2:0] ST_CMP   = 3'd6;
   localparam logic [2:0] ST_DONE  = 3'd7;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      idx_ff, idx_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [COUNT_BITS-1:0] corner_count_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_inside_ff, rsp_inside_in;
   logic                  rsp_keep_ff, rsp_keep_in;
   logic                  accept, write_go, test_go, few_corners, slot_ok;
   logic [CNT_W-1:0]      count_sat;
   logic [IDX_W-1:0]      wr_addr;
   logic [2*COORD_BITS-1:0] rd_data;
   logic                  dp_inside;
   pip_ctl_type           ctl;

   assign busy      = (state_ff != ST_IDLE);
   assign csr_ready = ~busy;
   assign accept    = start && !busy;

   assign few_corners = (corner_count_ff < COUNT_BITS'(MIN_CORNERS));
   assign count_sat   = ({27'd0, corner_count_ff} > 32'(MAX_CORNERS)) ?
                        CNT_W'(MAX_CORNERS) : CNT_W'(corner_count_ff);
   assign slot_ok     = ({28'd0, req_vertex_slot} < 32'(MAX_CORNERS));
   assign wr_addr     = IDX_W'({28'd0, req_vertex_slot});
   assign write_go    = accept && (req_mode == MODE_WRITE);
   assign test_go     = accept && (req_mode == MODE_TEST) && !few_corners;

   always_ff @(posedge clock) begin
      if (reset) begin
         corner_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         corner_count_ff <= csr_corner_count;
      end
   end

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_inside_in = 1'b0;
      rsp_keep_in   = 1'b0;
      ctl           = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = (req_mode == MODE_WRITE) || few_corners;
               rsp_keep_in  = (req_mode == MODE_TEST) && few_corners;
            end
            if (test_go) begin
               ctl.clear = 1'b1;
               count_in  = count_sat;
               idx_in    = count_sat - CNT_W'(1);
               state_in  = ST_PRIME;
            end
         end
         ST_PRIME: begin
            idx_in   = '0;
            state_in = ST_OLD;
         end
         ST_OLD: begin
            ctl.load_old = 1'b1;
            state_in     = ST_EDGE;
         end
         ST_EDGE: begin
            // next vertex address goes out while the products are formed
            ctl.load_edge = 1'b1;
            idx_in        = idx_ff + CNT_W'(1);
            state_in      = ST_MUL1;
         end
         ST_MUL1: begin
            ctl.mul_first = 1'b1;
            state_in      = ST_MUL2;
         end
         ST_MUL2: begin
            ctl.mul_second = 1'b1;
            state_in       = ST_CMP;
         end
         ST_CMP: begin
            ctl.compare = 1'b1;
            state_in    = (idx_ff == count_ff) ? ST_DONE : ST_EDGE;
         end
         ST_DONE: begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = dp_inside;
            rsp_keep_in   = dp_inside;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff <= rsp_inside_in;
      rsp_keep_ff   <= rsp_keep_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_inside_res = rsp_inside_ff;
   assign rsp_keep       = rsp_keep_ff;

   pip_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_CORNERS)
   ) u_corner_ram (
      .clock   (clock),
      .wr_en   (write_go && slot_ok),
      .wr_addr (wr_addr),
      .wr_data ({req_coord_x, req_coord_y}),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (rd_data)
   );

   pip_edge_dp #(
      .COORD_BITS (COORD_BITS)
   ) u_edge_dp (
      .clock       (clock),
      .reset       (reset),
      .ctl         (ctl),
      .point_x     (req_coord_x),
      .point_y     (req_coord_y),
      .rd_data     (rd_data),
      .inside_flag (dp_inside)
   );

   `PIP_ASSERT_SAME(a_rsp_when_free, rsp_valid, !busy, "result strobe while busy")
   `PIP_ASSERT_NEXT(a_write_rsp, write_go, rsp_valid && !rsp_inside_res && !rsp_keep, "bad write")
   `PIP_ASSERT_SAME(a_inside_keeps, rsp_valid && rsp_inside_res, rsp_keep, "inside without keep")
   `PIP_ASSERT_NEXT(a_test_busy, test_go, busy && !rsp_valid, "polygon walk did not start")

endmodule

`default_nettype wire

// ----- rtl/pip_ram.sv -----
// generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module pip_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/pip_edge_dp.sv -----
// edge datapath: crossing test, shared signed multiplier, product compare
// depends on pip_pkg
`default_nettype none

module pip_edge_dp
   import pip_pkg::*;
#(
   parameter int COORD_BITS = DEF_COORD_BITS
) (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire pip_ctl_type             ctl,
   input  wire logic [COORD_BITS-1:0]   point_x,
   input  wire logic [COORD_BITS-1:0]   point_y,
   input  wire logic [2*COORD_BITS-1:0] rd_data,
   output      logic                    inside_flag
);

   localparam int CW = COORD_BITS;
   localparam int DW = CW + 1;
   localparam int PW = 2 * DW;

   logic signed [CW-1:0] px_ff, py_ff, ox_ff, oy_ff;
   logic signed [CW-1:0] nx, ny, x1, y1, x2, y2;
   logic signed [DW-1:0] dl_ff, dx_ff, dy_ff, dp_ff;
   logic signed [DW-1:0] dl_in, dx_in, dy_in, dp_in;
   logic signed [DW-1:0] mul_a, mul_b;
   logic signed [PW-1:0] prod, p1_ff, p2_ff;
   logic                 hit_ff, hit_in;
   logic                 inside_ff;

   assign nx = $signed(rd_data[2*CW-1:CW]);
   assign ny = $signed(rd_data[CW-1:0]);

   always_comb begin
      if (nx > ox_ff) begin
         x1 = ox_ff;
         y1 = oy_ff;
         x2 = nx;
         y2 = ny;
      end else begin
         x1 = nx;
         y1 = ny;
         x2 = ox_ff;
         y2 = oy_ff;
      end
      // half-open span: exactly one end strictly left of the point
      hit_in = ((nx < px_ff) == (px_ff <= ox_ff));
      dl_in  = $signed({py_ff[CW-1], py_ff}) - $signed({y1[CW-1], y1});
      dx_in  = $signed({x2[CW-1], x2}) - $signed({x1[CW-1], x1});
      dy_in  = $signed({y2[CW-1], y2}) - $signed({y1[CW-1], y1});
      dp_in  = $signed({px_ff[CW-1], px_ff}) - $signed({x1[CW-1], x1});
   end

   // the one multiplier, shared by both products of an edge
   assign mul_a = ctl.mul_second ? dy_ff : dl_ff;
   assign mul_b = ctl.mul_second ? dp_ff : dx_ff;
   assign prod  = PW'(mul_a) * PW'(mul_b);

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         px_ff <= $signed(point_x);
         py_ff <= $signed(point_y);
      end
      if (ctl.load_old || ctl.load_edge) begin
         ox_ff <= nx;
         oy_ff <= ny;
      end
      if (ctl.load_edge) begin
         dl_ff <= dl_in;
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         dp_ff <= dp_in;
      end
      if (ctl.mul_first) begin
         p1_ff <= prod;
      end
      if (ctl.mul_second) begin
         p2_ff <= prod;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hit_ff    <= 1'b0;
         inside_ff <= 1'b0;
      end else begin
         if (ctl.load_edge) begin
            hit_ff <= hit_in;
         end
         if (ctl.clear) begin
            inside_ff <= 1'b0;
         end else if (ctl.compare && hit_ff && (p1_ff < p2_ff)) begin
            inside_ff <= ~inside_ff;
         end
      end
   end

   assign inside_flag = inside_ff;

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// testbench for point_in_polygon_test: a directed table of vertex writes, corner
// counts and point tests, then random polygons probed near vertices and edges
// depends on pip_pkg and the rtl of the block, nothing else
module tb_top;
   import pip_pkg::*;

   localparam int CW          = DEF_COORD_BITS;
   localparam int TOTAL_ITEMS = 1650;
   localparam int QUIET_TAIL  = TOTAL_ITEMS * 7 / 8;
   localparam int DRAIN_WAIT  = 4 * DEF_MAX_CORNERS + 8;

   localparam int SCALE_FULL = 0;
   localparam int SCALE_MID  = 1;
   localparam int SCALE_TINY = 2;
   localparam int SCALE_EDGE = 3;

   localparam logic [CW-1:0] C_MIN = 16'h8000;
   localparam logic [CW-1:0] C_MAX = 16'h7FFF;
   localparam logic [CW-1:0] EDGE_VALS [8] = '{16'h8000, 16'h8001, 16'hFFFF, 16'h0000,
                                               16'h0001, 16'h7FFE, 16'h7FFF, 16'hC000};

   typedef struct packed {
      logic inside_res;
      logic keep;
   } verdict_type;

   typedef enum logic [1:0] {ROW_SET_COUNT, ROW_TEST, ROW_WRITE} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic [SLOT_BITS-1:0]  slot;
      logic [CW-1:0]         x;
      logic [CW-1:0]         y;
      logic [COUNT_BITS-1:0] count;
      logic                  typed;
      logic                  inside_res;
      logic                  keep;
   } stim_row_type;

   localparam int NUM_ROWS = 24;
   // big square on the coordinate extremes, then triangle, saturated count, odd vertex
   localparam stim_row_type DIR_ROWS [NUM_ROWS] = '{
      '{ROW_TEST,      4'd0,  16'h0000, 16'h0000, 5'd0,  1'b1, 1'b0, 1'b1},
      '{ROW_TEST,      4'd0,  C_MIN,    C_MAX,    5'd0,  1'b1, 1'b0, 1'b1},
      '{ROW_WRITE,     4'd0,  C_MIN,    C_MIN,    5'd0,  1'b1, 1'b0, 1'b0},
      '{ROW_WRITE,     4'd1,  C_MAX,    C_MIN,    5'd0,  1'b1, 1'b0, 1'b0},
      '{ROW_WRITE,     4'd2,  C_MAX,    C_MAX,    5'd0,  1'b1, 1'b0, 1'b0},
      '{ROW_WRITE,     4'd3,  C_MIN,    C_MAX,    5'd0,  1'b1, 1'b0, 1'b0},
      '{ROW_SET_COUNT, 4'd0,  16'h0000, 16'h0000, 5'd2,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  C_MAX,    C_MIN,    5'd0,  1'b1, 1'b0, 1'b1},
      '{ROW_SET_COUNT, 4'd0,  16'h0000, 16'h0000, 5'd3,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h3E80, 16'hC180, 5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'hC180, 16'h3E80, 5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_SET_COUNT, 4'd0,  16'h0000, 16'h0000, 5'd4,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h0000, 16'h0000, 5'd0,  1'b1, 1'b1, 1'b1},
      '{ROW_TEST,      4'd0,  C_MIN,    16'h0000, 5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  C_MAX,    16'h0000, 5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h0000, C_MIN,    5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h8001, 16'h8001, 5'd0,  1'b1, 1'b1, 1'b1},
      '{ROW_SET_COUNT, 4'd0,  16'h0000, 16'h0000, 5'd31, 1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h0000, 16'h0000, 5'd0,  1'b1, 1'b1, 1'b1},
      '{ROW_SET_COUNT, 4'd0,  16'h0000, 16'h0000, 5'd16, 1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  C_MAX,    C_MAX,    5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_WRITE,     4'd15, 16'h0005, 16'hFFF9, 5'd0,  1'b1, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h0005, 16'hFFF9, 5'd0,  1'b0, 1'b0, 1'b0},
      '{ROW_TEST,      4'd0,  16'h0004, 16'hFFF9, 5'd0,  1'b0, 1'b0, 1'b0}
   };

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic                  req_mode = MODE_TEST;
   logic [SLOT_BITS-1:0]  req_vertex_slot = '0;
   logic [CW-1:0]         req_coord_x = '0;
   logic [CW-1:0]         req_coord_y = '0;
   logic                  rsp_valid;
   logic                  rsp_inside_res;
   logic                  rsp_keep;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [COUNT_BITS-1:0] csr_corner_count = '0;

   // polygon as the block should hold it
   logic signed [CW-1:0]  poly_x [DEF_MAX_CORNERS];
   logic signed [CW-1:0]  poly_y [DEF_MAX_CORNERS];
   logic [COUNT_BITS-1:0] poly_count = '0;
   bit [DEF_MAX_CORNERS-1:0] slot_written = '0;

   verdict_type pending_verdicts [$];
   int mismatches   = 0;
   int sent_items   = 0;
   int vertex_loads = 0;
   int real_tests   = 0;
   int inside_hits  = 0;
   int count_writes = 0;

   point_in_polygon_test i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_vertex_slot  (req_vertex_slot),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .rsp_valid        (rsp_valid),
      .rsp_inside_res   (rsp_inside_res),
      .rsp_keep         (rsp_keep),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_corner_count (csr_corner_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // crossing-number walk, starting with the edge that closes the polygon
   function automatic verdict_type classify_point(input logic signed [CW-1:0] px_in,
                                                  input logic signed [CW-1:0] py_in);
      int unsigned n;
      longint px, py, ax, ay, bx, by, lx, ly, hx, hy;
      verdict_type v;
      n = (poly_count > DEF_MAX_CORNERS) ? DEF_MAX_CORNERS : poly_count;
      v = '0;
      if (n < MIN_CORNERS) begin
         v.keep = 1'b1;
         return v;
      end
      px = px_in;
      py = py_in;
      ax = poly_x[n-1];
      ay = poly_y[n-1];
      for (int i = 0; i < n; i++) begin
         bx = poly_x[i];
         by = poly_y[i];
         // half-open x span, so vertical and zero-length edges never count
         if ((bx < px) == (px <= ax)) begin
            if (bx > ax) begin
               lx = ax; ly = ay; hx = bx; hy = by;
            end else begin
               lx = bx; ly = by; hx = ax; hy = ay;
            end
            if ((py - ly) * (hx - lx) < (hy - ly) * (px - lx))
               v.inside_res = ~v.inside_res;
         end
         ax = bx;
         ay = by;
      end
      v.keep = v.inside_res;
      return v;
   endfunction

   function automatic logic [CW-1:0] draw_coord(input int unsigned scale);
      case (scale)
         SCALE_TINY: return 16'(int'($urandom_range(0, 32)) - 16);
         SCALE_MID:  return 16'(int'($urandom_range(0, 8000)) - 4000);
         SCALE_EDGE: return EDGE_VALS[$urandom_range(0, 7)];
         default:    return 16'($urandom);
      endcase
   endfunction

   task automatic send_item(input logic mode, input logic [SLOT_BITS-1:0] slot,
                            input logic [CW-1:0] x, input logic [CW-1:0] y,
                            input bit typed, input verdict_type typed_v);
      verdict_type v;
      start           <= 1'b1;
      req_mode        <= mode;
      req_vertex_slot <= slot;
      req_coord_x     <= x;
      req_coord_y     <= y;
      do @(posedge clock); while (busy);
      if (mode == MODE_WRITE) begin
         poly_x[slot]       = x;
         poly_y[slot]       = y;
         slot_written[slot] = 1'b1;
         vertex_loads++;
         v = '0;
      end else begin
         v = classify_point(x, y);
         if (poly_count >= MIN_CORNERS)
            real_tests++;
      end
      if (typed)
         v = typed_v;
      inside_hits += v.inside_res;
      pending_verdicts = {pending_verdicts, v};
      sent_items++;
   endtask

   task automatic maybe_pause(input bit enable);
      if (enable && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      @(posedge clock);
      while (pending_verdicts.size() != 0) @(posedge clock);
   endtask

   // unwritten slots about to come into use get a copy of the slot before them (slot 0 a
   // random point), so the shape does not change and no unwritten vertex is ever walked
   task automatic program_corner_count(input logic [COUNT_BITS-1:0] cnt);
      int unsigned n;
      n = (cnt > DEF_MAX_CORNERS) ? DEF_MAX_CORNERS : cnt;
      for (int s = 0; s < n; s++)
         if (!slot_written[s])
            send_item(MODE_WRITE, SLOT_BITS'(s),
                      (s == 0) ? draw_coord(SCALE_FULL) : poly_x[s-1],
                      (s == 0) ? draw_coord(SCALE_FULL) : poly_y[s-1], 1'b0, '0);
      wait_idle();
      csr_valid        <= 1'b1;
      csr_corner_count <= cnt;
      do @(posedge clock); while (!csr_ready);
      csr_valid  <= 1'b0;
      poly_count = cnt;
      count_writes++;
   endtask

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_valid) begin
         if (pending_verdicts.size() == 0) begin
            $display("%0t: result with no transaction waiting: inside_res %0b keep %0b",
                     $time, rsp_inside_res, rsp_keep);
            mismatches++;
         end else begin
            want = pending_verdicts.pop_front();
            if (rsp_inside_res !== want.inside_res) begin
               $display("%0t: inside_res expected %0b got %0b",
                        $time, want.inside_res, rsp_inside_res);
               mismatches++;
            end
            if (rsp_keep !== want.keep) begin
               $display("%0t: keep expected %0b got %0b", $time, want.keep, rsp_keep);
               mismatches++;
            end
         end
      end
   end

   initial begin
      int unsigned   burst, walk_len, shape_scale, a, b;
      int            jitter;
      logic [CW-1:0] px, py;
      logic [COUNT_BITS-1:0] new_count;
      bit            gaps_on;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++) begin
         case (DIR_ROWS[r].kind)
            ROW_SET_COUNT: program_corner_count(DIR_ROWS[r].count);
            ROW_WRITE: send_item(MODE_WRITE, DIR_ROWS[r].slot, DIR_ROWS[r].x, DIR_ROWS[r].y,
                                 DIR_ROWS[r].typed,
                                 '{DIR_ROWS[r].inside_res, DIR_ROWS[r].keep});
            default: send_item(MODE_TEST, DIR_ROWS[r].slot, DIR_ROWS[r].x, DIR_ROWS[r].y,
                               DIR_ROWS[r].typed,
                               '{DIR_ROWS[r].inside_res, DIR_ROWS[r].keep});
         endcase
      end

      shape_scale = SCALE_FULL;
      while (sent_items < TOTAL_ITEMS) begin
         case ($urandom_range(0, 9))
            0:       new_count = COUNT_BITS'($urandom_range(0, 2));
            1:       new_count = COUNT_BITS'(MIN_CORNERS);
            2:       new_count = COUNT_BITS'(DEF_MAX_CORNERS);
            3:       new_count = COUNT_BITS'($urandom_range(17, 31));
            default: new_count = COUNT_BITS'($urandom_range(4, 15));
         endcase
         program_corner_count(new_count);
         walk_len = (new_count < MIN_CORNERS) ? DEF_MAX_CORNERS :
                    (new_count > DEF_MAX_CORNERS) ? DEF_MAX_CORNERS : new_count;
         gaps_on = ($urandom_range(0, 3) != 0) && (sent_items < QUIET_TAIL);

         // most phases load a fresh polygon before probing it
         if ($urandom_range(0, 2) != 0) begin
            shape_scale = $urandom_range(SCALE_FULL, SCALE_EDGE);
            for (int s = 0; s < walk_len; s++) begin
               maybe_pause(gaps_on);
               send_item(MODE_WRITE, SLOT_BITS'(s), draw_coord(shape_scale),
                         draw_coord(shape_scale), 1'b0, '0);
            end
         end

         burst = $urandom_range(6, 30);
         for (int k = 0; k < burst; k++) begin
            maybe_pause(gaps_on);
            a = $urandom_range(0, walk_len - 1);
            b = $urandom_range(0, walk_len - 1);
            jitter = int'($urandom_range(0, 4)) - 2;
            if ($urandom_range(0, 6) == 0) begin
               send_item(MODE_WRITE, SLOT_BITS'($urandom), draw_coord(shape_scale),
                         draw_coord(shape_scale), 1'b0, '0);
            end else begin
               case ($urandom_range(0, 9))
                  0, 1: begin
                     px = draw_coord(shape_scale);
                     py = draw_coord(shape_scale);
                  end
                  2: begin
                     px = 16'($urandom);
                     py = 16'($urandom);
                  end
                  3, 4: begin
                     px = 16'(int'(poly_x[a]) + jitter);
                     py = 16'(int'(poly_y[a]) + int'($urandom_range(0, 4)) - 2);
                  end
                  5, 6, 7: begin
                     px = 16'((int'(poly_x[a]) + int'(poly_x[b])) / 2 + jitter);
                     py = 16'((int'(poly_y[a]) + int'(poly_y[b])) / 2
                              + int'($urandom_range(0, 4)) - 2);
                  end
                  default: begin
                     // x right on a vertex exercises the half-open span
                     px = poly_x[a];
                     py = 16'((int'(poly_y[a]) + int'(poly_y[b])) / 2 + jitter);
                  end
               endcase
               send_item(MODE_TEST, SLOT_BITS'($urandom), px, py, 1'b0, '0);
            end
         end
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (pending_verdicts.size() != 0) begin
         $display("%0t: %0d results never arrived", $time, pending_verdicts.size());
         mismatches++;
      end
      $display("covered %0d transactions: %0d vertex writes, %0d tests on real polygons",
               sent_items, vertex_loads, real_tests);
      $display("%0d results inside, %0d corner_count settings", inside_hits, count_writes);
      if (mismatches == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("%0t: run did not finish in time", $time);
      $display("tb_top NOT OK");
      $finish;
   end

endmodule
